>>> hw/rtl/trimmed_mean_sample_averager_top_assert.svh
// Assertion macros shared by the trimmed-mean averager RTL.
`ifndef TRIMMED_MEAN_SAMPLE_AVERAGER_TOP_ASSERT_SVH
`define TRIMMED_MEAN_SAMPLE_AVERAGER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
`define TMSA_ASSERT(label, clock, reset, prop, msg) \
  label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define TMSA_ASSERT_NEVER(label, clock, reset, cond, msg) \
  label: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);
`else
`define TMSA_ASSERT(label, clock, reset, prop, msg)
`define TMSA_ASSERT_NEVER(label, clock, reset, cond, msg)
`endif

`endif

>>> hw/rtl/tmsa_pkg.sv
// Shared constants, types and states of the trimmed-mean averager.
package tmsa_pkg;

  localparam int MAX_SAMPLES = 20;
  localparam int SAMPLE_BITS = 12;
  localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W       = SAMPLE_BITS + CNT_W;
  localparam int STEP_W      = $clog2(SUM_W + 1);
  localparam int CFG_W       = 8;
  localparam int AVG_W       = 12;
  localparam int IN_DATA_W   = 16;
  localparam int OUT_DATA_W  = 16;

  typedef struct packed {
    logic [SUM_W-1:0]       sum;
    logic [SAMPLE_BITS-1:0] largest;
    logic [SAMPLE_BITS-1:0] smallest;
    logic [CNT_W-1:0]       ok_count;
    logic [CNT_W-1:0]       attempts;
  } accum_t;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic [SUM_W-1:0] quotient;
  } div_stat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TRIM,
    ST_DIV,
    ST_OUT
  } state_t;

endpackage

>>> hw/rtl/tmsa_accum.sv
// Burst accumulator: running sum, maximum, minimum and counts.
module tmsa_accum import tmsa_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   load,
  input  logic                   clear,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  logic                   sample_ok,
  output accum_t                 acc
);

  accum_t acc_next;

  always_comb begin
    acc_next = acc;
    if (clear) begin
      acc_next.sum      = '0;
      acc_next.largest  = '0;
      acc_next.smallest = '1;
      acc_next.ok_count = '0;
      acc_next.attempts = '0;
    end else if (load) begin
      if (sample_ok) begin
        acc_next.sum      = acc.sum + {{(SUM_W - SAMPLE_BITS){1'b0}}, sample};
        acc_next.ok_count = acc.ok_count + CNT_W'(1);
        if (sample > acc.largest) begin
          acc_next.largest = sample;
        end
        if (sample < acc.smallest) begin
          acc_next.smallest = sample;
        end
      end
      acc_next.attempts = acc.attempts + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc.sum      <= '0;
      acc.largest  <= '0;
      acc.smallest <= '1;
      acc.ok_count <= '0;
      acc.attempts <= '0;
    end else begin
      acc <= acc_next;
    end
  end

endmodule

>>> hw/rtl/tmsa_divider.sv
// Restoring divider, one quotient bit per cycle through a shared subtractor.
module tmsa_divider import tmsa_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  div_req_t  req,
  output div_stat_t stat
);

  logic [SUM_W-1:0]  quo;
  logic [CNT_W-1:0]  rem;
  logic [CNT_W-1:0]  divisor;
  logic [STEP_W-1:0] steps;
  logic              busy;

  logic [CNT_W:0]    rem_shift;
  logic [CNT_W:0]    rem_diff;
  logic              fits;

  always_comb begin
    rem_shift = {rem, quo[SUM_W-1]};
    rem_diff  = rem_shift - {1'b0, divisor};
    fits      = rem_shift >= {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      steps <= '0;
    end else if (req.start) begin
      busy  <= 1'b1;
      steps <= STEP_W'(SUM_W);
    end else if (busy) begin
      steps <= steps - STEP_W'(1);
      if (steps == STEP_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo     <= req.dividend;
      rem     <= '0;
      divisor <= req.divisor;
    end else if (busy) begin
      quo <= {quo[SUM_W-2:0], fits};
      rem <= fits ? rem_diff[CNT_W-1:0] : rem_shift[CNT_W-1:0];
    end
  end

  assign stat.busy     = busy;
  assign stat.quotient = quo;

endmodule

>>> hw/rtl/trimmed_mean_sample_averager_top.sv
// Top level of the trimmed-mean sample averager with burst sequencer.
// Each input word is one conversion attempt; an attempt that does not end the
// burst is accepted in the idle state, which keeps s_tready high. The attempt
// that ends the burst (count of attempts reaching the clamped sample_count)
// starts the result path with s_tready low: the trim state forms the trimmed
// sum and divisor (largest and smallest are dropped only when more than two
// samples were valid), the divide state runs the divider for 17 quotient bits
// at one bit per cycle and waits to see it finish, and the output state loads
// the output register once the previous result there has been taken. An empty
// burst skips the divider. The result waits in the output register while the
// next burst is taken in. sample_count resets to 1; the user is to write it
// through the cfg channel only while the block is idle, which the block
// itself does not enforce.
`include "trimmed_mean_sample_averager_top_assert.svh"

module trimmed_mean_sample_averager_top import tmsa_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // [11:0] sample
  input  logic                  s_tuser,   // [0] sample_ok
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // [11:0] average
  output logic                  m_tuser,   // [0] no_valid
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_W-1:0]      cfg_data
);

  state_t    state;
  state_t    state_next;
  accum_t    acc;
  div_req_t  div_req;
  div_stat_t div_stat;

  logic [CFG_W-1:0] sample_count;
  logic [CNT_W-1:0] burst_len;
  logic [CNT_W:0]   attempts_inc;
  logic             s_acc;
  logic             burst_done;
  logic             acc_clear;
  logic             out_free;
  logic             out_load;
  logic             res_err;

  assign cfg_ready = 1'b1;
  assign s_acc     = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= CFG_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      sample_count <= cfg_data;
    end
  end

  always_comb begin
    if (sample_count == '0) begin
      burst_len = CNT_W'(1);
    end else if (sample_count > CFG_W'(MAX_SAMPLES)) begin
      burst_len = CNT_W'(MAX_SAMPLES);
    end else begin
      burst_len = sample_count[CNT_W-1:0];
    end
    attempts_inc = {1'b0, acc.attempts} + (CNT_W + 1)'(1);
    burst_done   = attempts_inc >= {1'b0, burst_len};
  end

  tmsa_accum u_accum (
    .clk       (clk),
    .rst       (rst),
    .load      (s_acc),
    .clear     (acc_clear),
    .sample    (s_tdata[SAMPLE_BITS-1:0]),
    .sample_ok (s_tuser),
    .acc       (acc)
  );

  tmsa_divider u_divider (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .stat (div_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next       = state;
    s_tready         = 1'b0;
    acc_clear        = 1'b0;
    out_load         = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = acc.sum;
    div_req.divisor  = acc.ok_count;
    if (acc.ok_count > CNT_W'(2)) begin
      div_req.dividend = acc.sum - {{(SUM_W - SAMPLE_BITS){1'b0}}, acc.largest}
                                 - {{(SUM_W - SAMPLE_BITS){1'b0}}, acc.smallest};
      div_req.divisor  = acc.ok_count - CNT_W'(2);
    end
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_acc && burst_done) begin
          state_next = ST_TRIM;
        end
      end
      ST_TRIM: begin
        acc_clear = 1'b1;
        if (acc.ok_count == '0) begin
          state_next = ST_OUT;
        end else begin
          div_req.start = 1'b1;
          state_next    = ST_DIV;
        end
      end
      ST_DIV: begin
        if (!div_stat.busy) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == ST_TRIM) begin
      res_err <= acc.ok_count == '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tuser <= res_err;
      if (res_err) begin
        m_tdata <= '0;
      end else begin
        m_tdata <= {{(OUT_DATA_W - AVG_W){1'b0}}, div_stat.quotient[AVG_W-1:0]};
      end
    end
  end

  `TMSA_ASSERT(a_div_only_in_div, clk, rst, div_stat.busy |-> state == ST_DIV,
               "divider busy outside divide state")
  `TMSA_ASSERT(a_burst_end_trim, clk, rst, (s_acc && burst_done) |=> state == ST_TRIM,
               "burst end did not start result path")
  `TMSA_ASSERT(a_err_zero, clk, rst, (m_tvalid && m_tuser) |-> m_tdata == '0,
               "error result with nonzero average")
  `TMSA_ASSERT_NEVER(a_attempts_range, clk, rst, acc.attempts > CNT_W'(MAX_SAMPLES),
                     "attempt count beyond maximum burst")

endmodule
